>>> rtl/e2m_pkg.sv
// Package with shared constants and hash tables for the entropy to word index block.
package e2m_pkg;

  localparam int MAX_ENTROPY_BYTES_DEF = 32;
  localparam int INDEX_BITS            = 11;
  localparam int COUNT_W               = 6;
  localparam int ACC_W                 = 18;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> rtl/entropy_to_mnemonic_indices.sv
// Entropy bytes in, 11-bit mnemonic word indices out; one byte is taken per cycle while idle and
// the output register is free. After the last byte the entropy memory is read into the message
// block, the hash rounds run (one round per cycle), the digest byte is formed, then each entropy
// byte and the digest byte are read back and word indices are emitted, waiting while out_stall is high.
// A bad length gives its single error result in the cycle after the last byte.
// Synchronous reset clears the byte count, overflow flag, sequencer and output valid.
module entropy_to_mnemonic_indices #(
  parameter int MAX_ENTROPY_BYTES = e2m_pkg::MAX_ENTROPY_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       entropy_byte,
  input  logic                             last_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [e2m_pkg::INDEX_BITS-1:0]   word_index,
  output logic                             last_word,
  output logic                             length_error
);
  import e2m_pkg::*;

  localparam int AW = $clog2(MAX_ENTROPY_BYTES);

  typedef enum logic [2:0] {IDLE, LOAD, ROUND, DIGEST, EM_RD, EM_WR, EM_CHK} state_t;

  state_t               state;
  logic [COUNT_W-1:0]   byte_count;
  logic                 overflow_seen;
  logic [COUNT_W-1:0]   len;
  logic [6:0]           ld_pos;
  logic [6:0]           round_counter;
  logic [511:0]         win;
  logic [31:0]          va, vb, vc, vd, ve, vf, vg, vh;
  logic [7:0]           dig;
  logic [COUNT_W-1:0]   rd_ptr;
  logic [ACC_W-1:0]     acc;
  logic [4:0]           acc_cnt;
  logic [4:0]           word_k;
  logic [4:0]           words;

  logic                 in_acc;
  logic                 out_free;
  logic                 out_load;
  logic                 room;
  logic [COUNT_W-1:0]   count_next;
  logic                 overflow_next;
  logic                 bad_len;
  logic [AW-1:0]        ram_raddr;
  logic [7:0]           ram_q;
  logic [5:0]           ld_byte_pos;
  logic [8:0]           len_bits;
  logic [7:0]           ld_byte;
  logic [31:0]          w_new, t1, t2, ch, maj, s0, s1, w0, w1, w9, w14;
  logic [7:0]           em_byte;
  logic [ACC_W-1:0]     word_shifted;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  // Byte count update and length check on the incoming byte.
  always_comb begin
    room          = byte_count < COUNT_W'(MAX_ENTROPY_BYTES);
    count_next    = room ? byte_count + COUNT_W'(1) : byte_count;
    overflow_next = overflow_seen || !room;
    bad_len       = overflow_next || (count_next < COUNT_W'(16)) || (count_next[1:0] != 2'b00);
  end

  // The output register loads an error item or a word index.
  assign out_load = ((state == IDLE) && in_acc && last_byte && bad_len) ||
                    ((state == EM_CHK) && (acc_cnt >= 5'(INDEX_BITS)) && out_free);

  // Memory read address: block load walks bytes in order, emission walks its own pointer.
  assign ram_raddr = (state == LOAD) ? ld_pos[AW-1:0] : rd_ptr[AW-1:0];

  e2m_ram #(.WIDTH(8), .DEPTH(MAX_ENTROPY_BYTES)) u_store (
    .clk   (clk),
    .we    (in_acc && room),
    .waddr (byte_count[AW-1:0]),
    .wdata (entropy_byte),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Padded block byte for the position read in the previous cycle.
  always_comb begin
    ld_byte_pos = 6'(ld_pos - 7'd1);
    len_bits    = {len, 3'b000};
    if (ld_byte_pos < len) begin
      ld_byte = ram_q;
    end else if (ld_byte_pos == len) begin
      ld_byte = 8'h80;
    end else if (ld_byte_pos == 6'd62) begin
      ld_byte = {7'd0, len_bits[8]};
    end else if (ld_byte_pos == 6'd63) begin
      ld_byte = len_bits[7:0];
    end else begin
      ld_byte = 8'h00;
    end
  end

  // One compression round plus the next schedule word.
  always_comb begin
    w0    = win[511:480];
    w1    = win[479:448];
    w9    = win[223:192];
    w14   = win[63:32];
    s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    w_new = s1 + w9 + s0 + w0;
    ch    = (ve & vf) ^ (~ve & vg);
    maj   = (va & vb) ^ (va & vc) ^ (vb & vc);
    t1    = vh + (rotr(ve, 6) ^ rotr(ve, 11) ^ rotr(ve, 25)) + ch + SHA_K[round_counter[5:0]] + w0;
    t2    = (rotr(va, 2) ^ rotr(va, 13) ^ rotr(va, 22)) + maj;
  end

  // Emission: the stream byte after the entropy is the digest byte, whose top bits are the checksum.
  always_comb begin
    em_byte      = (rd_ptr == len) ? dig : ram_q;
    word_shifted = acc >> (acc_cnt - 5'(INDEX_BITS));
  end

  // Sequencer, datapath registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      byte_count    <= '0;
      overflow_seen <= 1'b0;
      round_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
      case (state)
        IDLE: begin
          if (in_acc) begin
            if (!last_byte) begin
              byte_count    <= count_next;
              overflow_seen <= overflow_next;
            end else begin
              byte_count    <= '0;
              overflow_seen <= 1'b0;
              len           <= count_next;
              if (bad_len) begin
                word_index   <= '0;
                last_word    <= 1'b1;
                length_error <= 1'b1;
              end else begin
                ld_pos <= '0;
                va <= SHA_IV[0]; vb <= SHA_IV[1]; vc <= SHA_IV[2]; vd <= SHA_IV[3];
                ve <= SHA_IV[4]; vf <= SHA_IV[5]; vg <= SHA_IV[6]; vh <= SHA_IV[7];
                state <= LOAD;
              end
            end
          end
        end
        LOAD: begin
          if (ld_pos != 7'd0) begin
            win <= {win[503:0], ld_byte};
          end
          ld_pos <= ld_pos + 7'd1;
          if (ld_pos == 7'd64) begin
            round_counter <= '0;
            state         <= ROUND;
          end
        end
        ROUND: begin
          win <= {win[479:0], w_new};
          vh <= vg; vg <= vf; vf <= ve; ve <= vd + t1;
          vd <= vc; vc <= vb; vb <= va; va <= t1 + t2;
          if (round_counter == 7'd63) begin
            round_counter <= '0;
            state         <= DIGEST;
          end else begin
            round_counter <= round_counter + 7'd1;
          end
        end
        DIGEST: begin
          dig     <= 8'((SHA_IV[0] + va) >> 24);
          rd_ptr  <= '0;
          acc     <= '0;
          acc_cnt <= '0;
          word_k  <= '0;
          words   <= 5'(len - (len >> 2));
          state   <= EM_RD;
        end
        EM_RD: begin
          state <= EM_WR;
        end
        EM_WR: begin
          acc     <= {acc[ACC_W-9:0], em_byte};
          acc_cnt <= acc_cnt + 5'd8;
          rd_ptr  <= rd_ptr + COUNT_W'(1);
          state   <= EM_CHK;
        end
        EM_CHK: begin
          if (acc_cnt >= 5'(INDEX_BITS)) begin
            if (out_free) begin
              word_index   <= word_shifted[INDEX_BITS-1:0];
              last_word    <= (word_k + 5'd1 == words);
              length_error <= 1'b0;
              acc_cnt      <= acc_cnt - 5'(INDEX_BITS);
              word_k       <= word_k + 5'd1;
              if (word_k + 5'd1 == words) begin
                state <= IDLE;
              end
            end
          end else begin
            state <= EM_RD;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/e2m_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module e2m_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
